[design/subscription_hash_row_table_macros.svh]
// Assertion macros for the subscription hash row table.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SUBSCRIPTION_HASH_ROW_TABLE_MACROS_SVH
`define SUBSCRIPTION_HASH_ROW_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, disabled while reset is asserted
`define SHRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SHRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SHRT_ASSERT(lbl, clk, rst_n, prop, msg)

`define SHRT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[design/shrt_pkg.sv]
// Shared types and constants of the subscription hash row table.
// No dependencies; used by shrt_front, shrt_back and the top level.
package shrt_pkg;

  localparam int DEF_ENTRIES  = 64;
  localparam int DEF_ROW_BITS = 8;

  localparam int ID_W        = 64;
  localparam int HASH_W      = 16;
  localparam int BASE_W      = 24;
  localparam int SUBIDX_W    = 25;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_MODE  = 1'b0,
    CFG_BASE_INDEX = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_COLLISION = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [HASH_W-1:0] hash;
  } item_t;

  // handshake between front queue and back engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

[design/shrt_front.sv]
// Front end: configuration registers, hash of incoming ids, two-entry item queue.
// Depends on shrt_pkg.
module shrt_front #(
  parameter int ROW_BITS = shrt_pkg::DEF_ROW_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [shrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_operation,
  input  logic [shrt_pkg::ID_W-1:0]       in_security_id,
  output shrt_pkg::queue_head_t           head,
  input  logic                            head_take,
  output logic [shrt_pkg::BASE_W-1:0]     base_index
);

  logic                          hash_mode_r;
  logic [shrt_pkg::BASE_W-1:0]   base_index_r;
  shrt_pkg::item_t               q_mem_r [2];
  logic                          wr_ptr_r;
  logic                          rd_ptr_r;
  logic [1:0]                    q_cnt_r;
  logic [1:0]                    q_cnt_nxt;
  logic                          push_ok;
  logic                          pop_ok;
  logic [shrt_pkg::HASH_W-1:0]   hash;
  logic [shrt_pkg::ID_W-1:0]     shifted;

  assign shifted = in_security_id >> ROW_BITS;

  always_comb begin
    if (hash_mode_r) begin
      hash = {8'h00, in_security_id[31:24]};
    end else begin
      hash = shifted[shrt_pkg::HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r  <= 1'b0;
      base_index_r <= '0;
    end else if (cfg_we) begin
      unique case (shrt_pkg::cfg_reg_t'(cfg_index))
        shrt_pkg::CFG_HASH_MODE:  hash_mode_r  <= cfg_data[0];
        shrt_pkg::CFG_BASE_INDEX: base_index_r <= cfg_data[shrt_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign full    = (q_cnt_r == 2'd2);
  assign push_ok = push && !full;
  assign pop_ok  = head_take && (q_cnt_r != 2'd0);

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (push_ok && !pop_ok) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= '{op:   shrt_pkg::op_t'(in_operation),
                             id:   in_security_id,
                             hash: hash};
    end
  end

  assign head.valid = (q_cnt_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];
  assign base_index = base_index_r;

endmodule

[design/shrt_back.sv]
// Back end: entry table, sequential scan engine and result register.
// Depends on shrt_pkg and subscription_hash_row_table_macros.svh.
`include "subscription_hash_row_table_macros.svh"

module shrt_back #(
  parameter int ENTRIES = shrt_pkg::DEF_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  shrt_pkg::queue_head_t            head,
  output logic                             head_take,
  input  logic [shrt_pkg::BASE_W-1:0]      base_index,
  output logic                             empty,
  input  logic                             pop,
  output logic [shrt_pkg::STATUS_W-1:0]    out_status,
  output logic [shrt_pkg::SUBIDX_W-1:0]    out_subscription_index,
  output logic [shrt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  logic [shrt_pkg::ID_W-1:0]   ids_mem   [ENTRIES];
  logic [shrt_pkg::HASH_W-1:0] hashes_mem[ENTRIES];

  state_t                        state_r, state_nxt;
  shrt_pkg::item_t               cur_r;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]              rd_pos_r;
  logic [shrt_pkg::ID_W-1:0]     rd_id_r;
  logic [shrt_pkg::HASH_W-1:0]   rd_hash_r;
  logic                          out_vld_r, out_vld_nxt;
  shrt_pkg::status_t             out_status_r, res_status;
  logic [shrt_pkg::SUBIDX_W-1:0] out_index_r, res_index;
  logic [31:0]                   count_wide;

  logic issue, hit, done_nohit, full_add, wr_en, res_set;

  assign head_take  = (state_r == S_IDLE) && head.valid && !out_vld_r;
  assign full_add   = head_take && (head.item.op == shrt_pkg::OP_ADD) &&
                      (count_r == CNT_W'(ENTRIES));
  assign issue      = (state_r == S_SCAN) && (idx_r < count_r);
  assign hit        = (state_r == S_SCAN) && rd_vld_r &&
                      ((cur_r.op == shrt_pkg::OP_ADD) ? (rd_hash_r == cur_r.hash)
                                                      : (rd_id_r == cur_r.id));
  assign done_nohit = (state_r == S_SCAN) && !issue && !rd_vld_r;
  assign wr_en      = done_nohit && (cur_r.op == shrt_pkg::OP_ADD);

  always_comb begin
    res_set    = 1'b0;
    res_status = shrt_pkg::ST_NOT_FOUND;
    res_index  = '0;
    priority if (full_add) begin
      res_set    = 1'b1;
      res_status = shrt_pkg::ST_FULL;
    end else if (hit) begin
      res_set = 1'b1;
      if (cur_r.op == shrt_pkg::OP_ADD) begin
        res_status = (rd_id_r == cur_r.id) ? shrt_pkg::ST_ALREADY
                                           : shrt_pkg::ST_COLLISION;
      end else begin
        res_status = shrt_pkg::ST_FOUND;
        res_index  = {1'b0, base_index} + shrt_pkg::SUBIDX_W'(rd_pos_r);
      end
    end else if (done_nohit) begin
      res_set    = 1'b1;
      res_status = (cur_r.op == shrt_pkg::OP_ADD) ? shrt_pkg::ST_ADDED
                                                  : shrt_pkg::ST_NOT_FOUND;
    end else begin
      res_set = 1'b0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    count_nxt  = count_r + CNT_W'(wr_en);
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (head_take && !full_add) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || done_nohit) begin
          state_nxt = S_IDLE;
        end else if (issue) begin
          idx_nxt    = idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_set) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      cur_r <= head.item;
    end
    if (res_set) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
    end
  end

  // table: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id_r   <= ids_mem[idx_r[IDX_W-1:0]];
      rd_hash_r <= hashes_mem[idx_r[IDX_W-1:0]];
      rd_pos_r  <= idx_r[IDX_W-1:0];
    end
    if (wr_en) begin
      ids_mem[count_r[IDX_W-1:0]]    <= cur_r.id;
      hashes_mem[count_r[IDX_W-1:0]] <= cur_r.hash;
    end
  end

  assign count_wide             = 32'(count_r);
  assign empty                  = !out_vld_r;
  assign out_status             = out_status_r;
  assign out_subscription_index = out_index_r;
  assign out_entry_count        = count_wide[shrt_pkg::COUNT_OUT_W-1:0];

  `SHRT_ASSERT(a_count_bound, clk, rst_n, (count_r <= CNT_W'(ENTRIES)), "entry count beyond table size")
  `SHRT_ASSERT(a_scan_bound, clk, rst_n, (idx_r <= count_r), "scan index past valid entries")
  `SHRT_ASSERT(a_slot_free, clk, rst_n, ((state_r == S_SCAN) |-> !out_vld_r), "scan running with result pending")
  `SHRT_ASSERT(a_write_grows, clk, rst_n, (wr_en |=> (count_r == $past(count_r) + CNT_W'(1))), "append did not bump count")

endmodule

[design/subscription_hash_row_table.sv]
// Subscription hash row table: one row of up to ENTRIES subscribed securities.
// Input queue (push/full) takes an operation and a 64-bit id; add appends an id
// unless the row is full or an entry with the same hash exists (already
// subscribed or collision); lookup returns base_index plus the matching position.
// Result queue (empty/pop) presents status, subscription index and entry count.
// Config: cfg_we/cfg_index/cfg_data write hash_mode (0) and base_index (1); the user
// must write them only while idle, which the block itself does not enforce. A front
// stage hashes accepted items into a two-entry queue; a back engine scans the entry
// table one stored entry per cycle through its single read port. An item with no hit
// is scanned over every stored entry; a hit ends the scan at the matching position,
// and an add to a full row is answered without a scan.
// The front keeps taking items into its queue while a result waits, so push is
// stalled only once both queue entries are in use.
// A stalled pop holds the result; the back engine starts no new item until it
// has been transferred. Reset (rst_n low, synchronous) empties both queues,
// clears the entry count and the control and configuration registers; table contents need no clearing.
// Depends on shrt_pkg, shrt_front and shrt_back.
module subscription_hash_row_table #(
  parameter int ENTRIES  = shrt_pkg::DEF_ENTRIES,
  parameter int ROW_BITS = shrt_pkg::DEF_ROW_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [shrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_operation,
  input  logic [shrt_pkg::ID_W-1:0]        in_security_id,
  output logic                             empty,
  input  logic                             pop,
  output logic [shrt_pkg::STATUS_W-1:0]    out_status,
  output logic [shrt_pkg::SUBIDX_W-1:0]    out_subscription_index,
  output logic [shrt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  shrt_pkg::queue_head_t       head;
  logic                        head_take;
  logic [shrt_pkg::BASE_W-1:0] base_index;

  shrt_front #(
    .ROW_BITS(ROW_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_security_id(in_security_id),
    .head          (head),
    .head_take     (head_take),
    .base_index    (base_index)
  );

  shrt_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .head_take             (head_take),
    .base_index            (base_index),
    .empty                 (empty),
    .pop                   (pop),
    .out_status            (out_status),
    .out_subscription_index(out_subscription_index),
    .out_entry_count       (out_entry_count)
  );

endmodule
